[sv/rmpsc_pkg.sv]
`default_nettype none
package rmpsc_pkg;

	localparam int unsigned GainW    = 31;
	localparam int unsigned PwmW     = 12;
	localparam int unsigned SpeedW   = 16;
	localparam int unsigned SwitchW  = 11;
	localparam int unsigned ErrW     = SpeedW + 1;
	localparam int unsigned CtrlW    = 32;
	localparam int unsigned QFracW   = 24;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 31;
	localparam int unsigned InDataW  = 56;
	localparam int unsigned OutDataW = 48;

	typedef enum logic [1:0] {
		MODE_CUTOFF     = 2'd0,
		MODE_ARM        = 2'd1,
		MODE_NON_MOMENT = 2'd2,
		MODE_MOMENT     = 2'd3
	} flight_mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_USE_INTEG   = 3'd3,
		REG_PWM_LOW     = 3'd4,
		REG_PWM_HIGH    = 3'd5
	} cfg_reg_t;

	localparam logic [SwitchW-1:0] ARM_THRESHOLD = 11'd500;
	localparam logic [SwitchW-1:0] NONMOMENT_TOP = 11'd1400;
	localparam logic [PwmW-1:0]    PWM_IDLE      = 12'd1000;
	localparam logic [PwmW-1:0]    PWM_ARMED     = 12'd1200;

	localparam logic [GainW-1:0]   PROP_GAIN_RST = 31'd5033;
	localparam logic [PwmW-1:0]    PWM_LOW_RST   = 12'd1000;
	localparam logic [PwmW-1:0]    PWM_HIGH_RST  = 12'd2000;

	localparam logic signed [CtrlW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [CtrlW-1:0] SAT_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

[sv/rc_mode_pid_speed_controller.sv]
// channel  direction  signals                                   payload
// s_axis   in         s_axis_tvalid/tready/tdata[55:0]          setpoint, speed, switches
// m_axis   out        m_axis_tvalid/tready/tdata[47:0]          mode, control, pwm
// cfg      in         cfg_valid/cfg_ready/cfg_index/cfg_data    gains, limits
//
// one item per cycle unless the output stalls; items go through the input register
// and output register; the single compute stage also updates error and integral state
// arst_n clears valid flags and error/integral state and presets the cfg registers
// a stalled output holds its result; the input register still fills behind it
// cfg is always ready and must be written only while the block is idle; not enforced
`default_nettype none
module rc_mode_pid_speed_controller
	import rmpsc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// speed_target[15:0], measured_speed[31:16], arm_switch[42:32], mode_switch[53:43]
	input  wire logic [InDataW-1:0]   s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// flight_mode[1:0], pid_output[33:2], pwm_command[45:34]
	output logic [OutDataW-1:0]       m_axis_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CfgIdxW-1:0]   cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	logic [GainW-1:0] prop_gain_q;
	logic [GainW-1:0] integ_gain_q;
	logic [GainW-1:0] deriv_gain_q;
	logic             use_integ_q;
	logic [PwmW-1:0]  pwm_low_q;
	logic [PwmW-1:0]  pwm_high_q;

	logic signed [ErrW-1:0]  prev_err_q;
	logic signed [CtrlW-1:0] err_sum_q;

	logic                      valid_s1;
	logic signed [SpeedW-1:0]  target_s1;
	logic signed [SpeedW-1:0]  meas_s1;
	logic [SwitchW-1:0]        arm_sw_s1;
	logic [SwitchW-1:0]        mode_sw_s1;

	logic                      out_valid_q;
	flight_mode_t              out_mode_q;
	logic signed [CtrlW-1:0]   out_ctrl_q;
	logic [PwmW-1:0]           out_pwm_q;

	logic                      advance;
	logic                      in_take;
	flight_mode_t              mode;
	logic signed [ErrW-1:0]    err;
	logic signed [ErrW:0]      diff;
	logic signed [CtrlW:0]     sum_raw;
	logic signed [CtrlW-1:0]   sum_sat;
	logic signed [CtrlW-1:0]   sum_used;
	logic signed [CtrlW-1:0]   gp;
	logic signed [CtrlW-1:0]   gi;
	logic signed [CtrlW-1:0]   gd;
	logic signed [48:0]        p_term;
	logic signed [49:0]        d_term;
	logic signed [63:0]        i_term;
	logic signed [64:0]        acc;
	logic signed [40:0]        quo;
	logic signed [40:0]        quo_adj;
	logic signed [CtrlW-1:0]   ctrl;
	logic signed [CtrlW-1:0]   low_ext;
	logic signed [CtrlW-1:0]   high_ext;
	logic [PwmW-1:0]           pwm;
	logic signed [ErrW-1:0]    prev_err_d;
	logic signed [CtrlW-1:0]   err_sum_d;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// mode classification
	always_comb begin
		if (arm_sw_s1 > ARM_THRESHOLD) begin
			if (mode_sw_s1 < ARM_THRESHOLD) begin
				mode = MODE_ARM;
			end else if (mode_sw_s1 > ARM_THRESHOLD && mode_sw_s1 < NONMOMENT_TOP) begin
				mode = MODE_NON_MOMENT;
			end else begin
				mode = MODE_MOMENT;
			end
		end else begin
			mode = MODE_CUTOFF;
		end
	end

	// error, saturated integral and q.24 control sum
	always_comb begin
		err  = ErrW'(target_s1) - ErrW'(meas_s1);
		diff = (ErrW+1)'(err) - (ErrW+1)'(prev_err_q);

		sum_raw = (CtrlW+1)'(err_sum_q) + (CtrlW+1)'(err);
		if (sum_raw[CtrlW] != sum_raw[CtrlW-1]) begin
			sum_sat = sum_raw[CtrlW] ? SAT_MIN : SAT_MAX;
		end else begin
			sum_sat = sum_raw[CtrlW-1:0];
		end
		sum_used = use_integ_q ? sum_sat : err_sum_q;

		gp = $signed({1'b0, prop_gain_q});
		gi = $signed({1'b0, integ_gain_q});
		gd = $signed({1'b0, deriv_gain_q});

		p_term = 49'(err) * 49'(gp);
		d_term = 50'(diff) * 50'(gd);
		i_term = use_integ_q ? (64'(sum_sat) * 64'(gi)) : 64'sd0;
		acc    = 65'(p_term) + 65'(d_term) + 65'(i_term);

		// truncate toward zero
		quo     = acc[64:QFracW];
		quo_adj = quo + $signed({40'd0, (acc[64] && (|acc[QFracW-1:0]))});
		if (quo_adj > 41'(SAT_MAX)) begin
			ctrl = SAT_MAX;
		end else if (quo_adj < 41'(SAT_MIN)) begin
			ctrl = SAT_MIN;
		end else begin
			ctrl = quo_adj[CtrlW-1:0];
		end
	end

	// pwm selection and state update
	always_comb begin
		low_ext  = $signed({20'd0, pwm_low_q});
		high_ext = $signed({20'd0, pwm_high_q});
		case (mode)
			MODE_CUTOFF: begin
				pwm        = PWM_IDLE;
				prev_err_d = '0;
				err_sum_d  = '0;
			end
			MODE_ARM: begin
				pwm        = PWM_ARMED;
				prev_err_d = '0;
				err_sum_d  = '0;
			end
			MODE_NON_MOMENT: begin
				pwm        = PWM_IDLE;
				prev_err_d = '0;
				err_sum_d  = sum_used;
			end
			default: begin
				if (ctrl < low_ext) begin
					pwm = pwm_low_q;
				end else if (ctrl > high_ext) begin
					pwm = pwm_high_q;
				end else begin
					pwm = ctrl[PwmW-1:0];
				end
				prev_err_d = err;
				err_sum_d  = sum_used;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			use_integ_q  <= 1'b0;
			pwm_low_q    <= PWM_LOW_RST;
			pwm_high_q   <= PWM_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GainW-1:0];
				REG_INTEG_GAIN: integ_gain_q <= cfg_data[GainW-1:0];
				REG_DERIV_GAIN: deriv_gain_q <= cfg_data[GainW-1:0];
				REG_USE_INTEG:  use_integ_q  <= cfg_data[0];
				REG_PWM_LOW:    pwm_low_q    <= cfg_data[PwmW-1:0];
				REG_PWM_HIGH:   pwm_high_q   <= cfg_data[PwmW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			prev_err_q  <= '0;
			err_sum_q   <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				prev_err_q  <= prev_err_d;
				err_sum_q   <= err_sum_d;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			target_s1  <= s_axis_tdata[15:0];
			meas_s1    <= s_axis_tdata[31:16];
			arm_sw_s1  <= s_axis_tdata[42:32];
			mode_sw_s1 <= s_axis_tdata[53:43];
		end
		if (advance) begin
			out_mode_q <= mode;
			out_ctrl_q <= ctrl;
			out_pwm_q  <= pwm;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_pwm_q, out_ctrl_q, out_mode_q};

endmodule
`default_nettype wire

[tb/sv/tb_rc_mode_pid_speed_controller.sv]
`timescale 1ns / 1ps

module tb_rc_mode_pid_speed_controller;
	import rmpsc_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int MODE_W = $bits(flight_mode_t);
	localparam logic [SpeedW-1:0] SPEED_MAX = 16'h7FFF;
	localparam logic [SpeedW-1:0] SPEED_MIN = 16'h8000;
	localparam logic [SwitchW-1:0] SW_MAX = {SwitchW{1'b1}};
	localparam logic [CfgDataW-1:0] GAIN_MAX = {GainW{1'b1}};
	localparam logic [CfgDataW-1:0] UNIT_GAIN = CfgDataW'(1 << QFracW);
	localparam logic [PwmW-1:0] PWM_MAX = {PwmW{1'b1}};
	localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE = 3'd6;
	localparam int WINDUP_UP_ITEMS = 300;
	localparam int WINDUP_DOWN_ITEMS = 600;

	typedef struct packed {
		flight_mode_t mode;
		logic signed [CtrlW-1:0] ctrl;
		logic [PwmW-1:0] pwm;
	} ctrl_command_t;

	class speed_ctrl_scoreboard;
		logic [GainW-1:0] kp, ki, kd;
		bit integ_on;
		logic [PwmW-1:0] pwm_lo, pwm_hi;
		logic signed [ErrW-1:0] last_err;
		logic signed [CtrlW-1:0] integ_acc;
		ctrl_command_t pending_commands[$];
		int mismatches;

		function new();
			kp = PROP_GAIN_RST;
			ki = '0;
			kd = '0;
			integ_on = 1'b0;
			pwm_lo = PWM_LOW_RST;
			pwm_hi = PWM_HIGH_RST;
			last_err = '0;
			integ_acc = '0;
			mismatches = 0;
		endfunction

		function int pending();
			return pending_commands.size();
		endfunction

		function longint sat_word(input longint v);
			if (v > longint'(SAT_MAX))
				return longint'(SAT_MAX);
			if (v < longint'(SAT_MIN))
				return longint'(SAT_MIN);
			return v;
		endfunction

		function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
			case (idx)
				REG_PROP_GAIN: kp = val[GainW-1:0];
				REG_INTEG_GAIN: ki = val[GainW-1:0];
				REG_DERIV_GAIN: kd = val[GainW-1:0];
				REG_USE_INTEG: integ_on = val[0];
				REG_PWM_LOW: pwm_lo = val[PwmW-1:0];
				REG_PWM_HIGH: pwm_hi = val[PwmW-1:0];
				default: ;
			endcase
		endfunction

		function void take_sample(input logic [InDataW-1:0] d);
			logic signed [SpeedW-1:0] tgt, meas;
			logic [SwitchW-1:0] arm_sw, mode_sw;
			logic signed [ErrW-1:0] err;
			longint err_l, prev_l, kp_l, ki_l, kd_l, lo_l, hi_l, acc, ctrl;
			ctrl_command_t c;
			tgt = d[SpeedW-1:0];
			meas = d[2*SpeedW-1:SpeedW];
			arm_sw = d[2*SpeedW +: SwitchW];
			mode_sw = d[2*SpeedW+SwitchW +: SwitchW];
			err = tgt - meas;
			err_l = err;
			prev_l = last_err;
			kp_l = kp;
			ki_l = ki;
			kd_l = kd;
			lo_l = pwm_lo;
			hi_l = pwm_hi;

			if (arm_sw <= ARM_THRESHOLD)
				c.mode = MODE_CUTOFF;
			else if (mode_sw < ARM_THRESHOLD)
				c.mode = MODE_ARM;
			else if (mode_sw > ARM_THRESHOLD && mode_sw < NONMOMENT_TOP)
				c.mode = MODE_NON_MOMENT;
			else
				c.mode = MODE_MOMENT;

			acc = err_l * kp_l + (err_l - prev_l) * kd_l;
			if (integ_on) begin
				integ_acc = CtrlW'(sat_word(longint'(integ_acc) + err_l));
				acc += longint'(integ_acc) * ki_l;
			end
			// integer part, truncated toward zero
			ctrl = sat_word(acc / (longint'(1) <<< QFracW));
			c.ctrl = ctrl[CtrlW-1:0];
			last_err = err;

			case (c.mode)
				MODE_CUTOFF: begin
					integ_acc = '0;
					last_err = '0;
					c.pwm = PWM_IDLE;
				end
				MODE_ARM: begin
					integ_acc = '0;
					last_err = '0;
					c.pwm = PWM_ARMED;
				end
				MODE_NON_MOMENT: begin
					last_err = '0;
					c.pwm = PWM_IDLE;
				end
				default: begin
					if (ctrl < lo_l)
						c.pwm = pwm_lo;
					else if (ctrl > hi_l)
						c.pwm = pwm_hi;
					else
						c.pwm = ctrl[PwmW-1:0];
				end
			endcase
			pending_commands.push_back(c);
		endfunction

		task flag_mismatch(input string msg);
			$display("%0t ns: %s", $time, msg);
			mismatches++;
		endtask

		task check_command(input logic [OutDataW-1:0] d);
			ctrl_command_t want;
			logic [MODE_W-1:0] got_mode;
			logic [CtrlW-1:0] got_ctrl;
			logic [PwmW-1:0] got_pwm;
			got_mode = d[MODE_W-1:0];
			got_ctrl = d[MODE_W +: CtrlW];
			got_pwm = d[MODE_W+CtrlW +: PwmW];
			if (pending_commands.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %h", d));
				return;
			end
			want = pending_commands.pop_front();
			if (got_mode !== want.mode)
				flag_mismatch($sformatf("flight_mode: got %0d expected %0d", got_mode, want.mode));
			if (got_ctrl !== want.ctrl)
				flag_mismatch($sformatf("pid_output: got %0d expected %0d",
					$signed(got_ctrl), want.ctrl));
			if (got_pwm !== want.pwm)
				flag_mismatch($sformatf("pwm_command: got %0d expected %0d", got_pwm, want.pwm));
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [InDataW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	bit idle_en = 1'b1;
	speed_ctrl_scoreboard sb = new();

	rc_mode_pid_speed_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * 2_000_000);
		$display("tb: failure");
		$finish;
	end

	// transaction monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				sb.take_sample(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_command(m_axis_tdata);
		end
	end

	always begin
		@(posedge clk);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		m_axis_tready <= 1'b1;
	end

	function automatic logic [InDataW-1:0] pack_item(input int tgt, meas,
			input int arm_sw, mode_sw);
		return InDataW'({SwitchW'(mode_sw), SwitchW'(arm_sw), SpeedW'(meas), SpeedW'(tgt)});
	endfunction

	function automatic logic [CfgDataW-1:0] with_junk(input logic [CfgDataW-1:0] v, input int w);
		logic [CfgDataW-1:0] junk;
		junk = CfgDataW'($urandom);
		junk = junk << w;
		return junk | v;
	endfunction

	function automatic logic [CfgDataW-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return GAIN_MAX;
			2: return CfgDataW'($urandom_range(0, 1 << (QFracW + 1)));
			3: return CfgDataW'($urandom_range(0, 1 << (QFracW - 4)));
			default: return CfgDataW'($urandom >> $urandom_range(1, 31));
		endcase
	endfunction

	function automatic logic [CfgDataW-1:0] rand_limit();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return CfgDataW'(PWM_MAX);
			default: return CfgDataW'($urandom_range(0, PWM_MAX));
		endcase
	endfunction

	task automatic send_item(input logic [InDataW-1:0] d);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= InDataW'({$urandom, $urandom});
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_config(input logic [CfgDataW-1:0] kp, ki, kd, use_i, lo, hi,
			input bit spare);
		put_reg(REG_PROP_GAIN, kp);
		put_reg(REG_INTEG_GAIN, ki);
		put_reg(REG_DERIV_GAIN, kd);
		put_reg(REG_USE_INTEG, use_i);
		put_reg(REG_PWM_LOW, lo);
		put_reg(REG_PWM_HIGH, hi);
		if (spare)
			put_reg(CfgIdxW'($urandom_range(CFG_IDX_SPARE, (1 << CfgIdxW) - 1)),
				CfgDataW'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic directed_items();
		send_item(pack_item(SPEED_MAX, SPEED_MIN, 0, 0));
		send_item(pack_item(SPEED_MIN, SPEED_MAX, ARM_THRESHOLD, SW_MAX));
		send_item(pack_item(100, 0, ARM_THRESHOLD + 1, ARM_THRESHOLD - 1));
		send_item(pack_item(100, 0, SW_MAX, ARM_THRESHOLD));
		send_item(pack_item(100, 0, SW_MAX, ARM_THRESHOLD + 1));
		send_item(pack_item(-100, 0, SW_MAX, NONMOMENT_TOP - 1));
		send_item(pack_item(0, 0, SW_MAX, NONMOMENT_TOP));
		send_item(pack_item(0, 0, SW_MAX, 0));

		drain();
		write_config(UNIT_GAIN, UNIT_GAIN, UNIT_GAIN, CfgDataW'(1), CfgDataW'(PWM_LOW_RST),
			CfgDataW'(PWM_HIGH_RST), 1'b0);
		send_item(pack_item(200, 0, SW_MAX, SW_MAX));
		send_item(pack_item(0, 0, SW_MAX, SW_MAX));
		send_item(pack_item(-300, 0, SW_MAX, SW_MAX));
		send_item(pack_item(700, 0, SW_MAX, SW_MAX));
		send_item(pack_item(10, 0, SW_MAX, SW_MAX));
		send_item(pack_item(0, 0, 0, 0));

		// low limit above high limit
		drain();
		write_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, CfgDataW'(1), CfgDataW'(3000),
			CfgDataW'(100), 1'b0);
		send_item(pack_item(1, 0, SW_MAX, SW_MAX));
		send_item(pack_item(40, 0, SW_MAX, SW_MAX));
		send_item(pack_item(SPEED_MAX, SPEED_MIN, SW_MAX, SW_MAX));
		send_item(pack_item(SPEED_MIN, SPEED_MAX, SW_MAX, SW_MAX));

		// half gain, p only: rounding toward zero
		drain();
		write_config(UNIT_GAIN >> 1, '0, '0, '0, '0, CfgDataW'(PWM_MAX), 1'b0);
		send_item(pack_item(-1, 0, SW_MAX, SW_MAX));
		send_item(pack_item(-3, 0, SW_MAX, SW_MAX));
		send_item(pack_item(3, 0, SW_MAX, SW_MAX));
		send_item(pack_item(SPEED_MAX, SPEED_MIN, SW_MAX, SW_MAX));
	endtask

	task automatic random_phase(input int n_items, input bit allow_idle);
		int left, run_len, k, r;
		flight_mode_t kind;
		logic [SpeedW-1:0] tgt, meas;
		logic [SwitchW-1:0] arm_sw, mode_sw;
		drain();
		idle_en = allow_idle && ($urandom_range(0, 3) != 0);
		write_config(rand_gain(), rand_gain(), rand_gain(),
			with_junk(CfgDataW'($urandom_range(0, 1)), 1),
			with_junk(rand_limit(), PwmW), with_junk(rand_limit(), PwmW), $urandom_range(0, 1));
		left = n_items;
		while (left > 0) begin
			run_len = $urandom_range(1, 30);
			r = $urandom_range(0, 9);
			kind = (r == 0) ? MODE_CUTOFF : (r == 1) ? MODE_ARM :
				(r < 4) ? MODE_NON_MOMENT : MODE_MOMENT;
			for (k = 0; k < run_len && left > 0; k++) begin
				arm_sw = ($urandom_range(0, 7) == 0) ? ARM_THRESHOLD + 1 :
					SwitchW'($urandom_range(ARM_THRESHOLD + 1, SW_MAX));
				case (kind)
					MODE_CUTOFF: begin
						arm_sw = SwitchW'($urandom_range(0, ARM_THRESHOLD));
						mode_sw = SwitchW'($urandom);
					end
					MODE_ARM: mode_sw = SwitchW'($urandom_range(0, ARM_THRESHOLD - 1));
					MODE_NON_MOMENT: mode_sw =
						SwitchW'($urandom_range(ARM_THRESHOLD + 1, NONMOMENT_TOP - 1));
					default: mode_sw = ($urandom_range(0, 7) == 0) ? ARM_THRESHOLD :
						SwitchW'($urandom_range(NONMOMENT_TOP, SW_MAX));
				endcase
				if ($urandom_range(0, 19) == 0) begin
					arm_sw = SwitchW'($urandom);
					mode_sw = SwitchW'($urandom);
				end
				case ($urandom_range(0, 7))
					0: begin
						tgt = SpeedW'($urandom);
						meas = SpeedW'($urandom);
					end
					1: begin
						tgt = $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
						meas = $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
					end
					default: begin
						tgt = SpeedW'($urandom);
						meas = SpeedW'(tgt - ($urandom_range(0, 4000) - 2000));
					end
				endcase
				send_item(pack_item(tgt, meas, arm_sw, mode_sw));
				left--;
			end
		end
	endtask

	// large error sum in both directions, with the integral alone driving the output
	task automatic integral_windup();
		int k;
		idle_en = 1'b0;
		drain();
		write_config('0, UNIT_GAIN, '0, CfgDataW'(1), CfgDataW'(PWM_LOW_RST),
			CfgDataW'(PWM_HIGH_RST), 1'b0);
		send_item(pack_item(0, 0, 0, 0));
		for (k = 0; k < WINDUP_UP_ITEMS; k++)
			send_item(pack_item(SPEED_MAX, SPEED_MIN, SW_MAX, SW_MAX));
		drain();
		write_config('0, GAIN_MAX, '0, CfgDataW'(1), CfgDataW'(PWM_LOW_RST),
			CfgDataW'(PWM_HIGH_RST), 1'b0);
		repeat (4) send_item(pack_item(0, 0, SW_MAX, SW_MAX));
		drain();
		write_config('0, UNIT_GAIN, '0, CfgDataW'(1), CfgDataW'(PWM_LOW_RST),
			CfgDataW'(PWM_HIGH_RST), 1'b0);
		for (k = 0; k < WINDUP_DOWN_ITEMS; k++)
			send_item(pack_item(SPEED_MIN, SPEED_MAX, SW_MAX, SW_MAX));
		drain();
		write_config('0, GAIN_MAX, '0, CfgDataW'(1), CfgDataW'(PWM_LOW_RST),
			CfgDataW'(PWM_HIGH_RST), 1'b0);
		repeat (4) send_item(pack_item(0, 0, SW_MAX, SW_MAX));
		send_item(pack_item(0, 0, 0, 0));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		repeat (7) random_phase(150, 1'b1);
		integral_windup();
		random_phase(150, 1'b0);
		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
sv/rmpsc_pkg.sv
sv/rc_mode_pid_speed_controller.sv
tb/sv/tb_rc_mode_pid_speed_controller.sv
